@@ hdl/tsie_pkg.sv @@
package tsie_pkg;

	localparam int STACK_DEPTH_DEF = 64;
	localparam int VALUE_WIDTH_DEF = 16;
	localparam int CHAR_WIDTH = 8;
	localparam int STATUS_WIDTH = 2;
	localparam int VALUE_OUT_WIDTH = 16;

	localparam logic [CHAR_WIDTH-1:0] CH_ZERO = 8'd48;
	localparam logic [CHAR_WIDTH-1:0] CH_NINE = 8'd57;
	localparam logic [CHAR_WIDTH-1:0] CH_OPEN = 8'd40;
	localparam logic [CHAR_WIDTH-1:0] CH_CLOSE = 8'd41;
	localparam logic [CHAR_WIDTH-1:0] CH_MUL = 8'd42;
	localparam logic [CHAR_WIDTH-1:0] CH_ADD = 8'd43;
	localparam logic [CHAR_WIDTH-1:0] CH_SUB = 8'd45;

	typedef enum logic [1:0] {
		OP_OPEN = 2'd0,
		OP_ADD = 2'd1,
		OP_SUB = 2'd2,
		OP_MUL = 2'd3
	} op_t;

	typedef enum logic [STATUS_WIDTH-1:0] {
		ST_ACCEPTED = 2'd0,
		ST_INVALID = 2'd1,
		ST_FAULT = 2'd2,
		ST_RESULT = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		STK_NONE,
		STK_PUSH,
		STK_POP2,
		STK_POP1_REPLACE
	} stk_cmd_t;

	typedef struct packed {
		stk_cmd_t cmd;
		logic clear;
	} stack_ctl_t;

endpackage

@@ hdl/tsie_in_if.sv @@
interface tsie_in_if;
	import tsie_pkg::*;

	logic valid;
	logic ready;
	logic [CHAR_WIDTH-1:0] char_code;
	logic end_of_expression;

	modport source (output valid, output char_code, output end_of_expression, input ready);
	modport sink (input valid, input char_code, input end_of_expression, output ready);

endinterface

@@ hdl/tsie_out_if.sv @@
interface tsie_out_if;
	import tsie_pkg::*;

	logic valid;
	logic ready;
	logic [STATUS_WIDTH-1:0] status;
	logic signed [VALUE_OUT_WIDTH-1:0] value;

	modport source (output valid, output status, output value, input ready);
	modport sink (input valid, input status, input value, output ready);

endinterface

@@ hdl/tsie_stack.sv @@
module tsie_stack #(
	parameter int WIDTH = tsie_pkg::VALUE_WIDTH_DEF,
	parameter int DEPTH = tsie_pkg::STACK_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input tsie_pkg::stack_ctl_t ctl,
	input logic [WIDTH-1:0] push_data,
	output logic [WIDTH-1:0] top0,
	output logic [WIDTH-1:0] top1,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	import tsie_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);

	// The two top entries live in registers; the next two below are prefetched
	// from the memory, so a double pop takes its new tops straight from registers.
	logic [WIDTH-1:0] mem [2**AW];
	logic [CW-1:0] count_q;
	logic [WIDTH-1:0] top0_q;
	logic [WIDTH-1:0] top1_q;
	logic [WIDTH-1:0] pfa_q;
	logic [WIDTH-1:0] pfb_q;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd5_addr;
	logic [AW-1:0] rd6_addr;
	logic [CW-1:0] cnt_m2;
	logic [CW-1:0] cnt_m5;
	logic [CW-1:0] cnt_m6;

	assign cnt_m2 = count_q - CW'(2);
	assign cnt_m5 = count_q - CW'(5);
	assign cnt_m6 = count_q - CW'(6);
	assign wr_addr = cnt_m2[AW-1:0];
	assign rd5_addr = cnt_m5[AW-1:0];
	assign rd6_addr = cnt_m6[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.clear) begin
			count_q <= '0;
		end else begin
			case (ctl.cmd)
				STK_PUSH: count_q <= count_q + CW'(1);
				STK_POP2: count_q <= count_q - CW'(2);
				STK_POP1_REPLACE: count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.cmd)
			STK_PUSH: begin
				mem[wr_addr] <= top1_q;
				top0_q <= push_data;
				top1_q <= top0_q;
				pfa_q <= top1_q;
				pfb_q <= pfa_q;
			end
			STK_POP2: begin
				top0_q <= pfa_q;
				top1_q <= pfb_q;
				pfa_q <= mem[rd5_addr];
				pfb_q <= mem[rd6_addr];
			end
			STK_POP1_REPLACE: begin
				top0_q <= push_data;
				top1_q <= pfa_q;
				pfa_q <= pfb_q;
				pfb_q <= mem[rd5_addr];
			end
			default: begin
			end
		endcase
	end

	assign top0 = top0_q;
	assign top1 = top1_q;
	assign count = count_q;

endmodule

@@ hdl/two_stack_infix_evaluator.sv @@
// Evaluates fully parenthesised integer expressions fed one ASCII character per
// beat on the expr channel; the end_of_expression flag marks the last character.
// Every input beat produces exactly one beat on the result channel, carrying a
// status code and the current top operand, or the final value on the last beat.
// Digits push operands, the characters for open bracket, plus, minus and times
// push operators, and a closing bracket reduces the innermost bracketed term.
// Any fault is sticky until the end of the expression, which clears both stacks.
// Each accepted input beat yields a registered result beat, and one character
// is taken every cycle unless the receiver stalls: the stack tops are held in
// registers and the entries below them are prefetched from the stack memories,
// so each character needs one add, subtract or multiply and one stack update.
// The result register decouples the channels: input is taken whenever the
// result register is empty or is being emptied in the same cycle, so a stalled
// receiver stalls the input only once a result is waiting.
// Reset empties both stacks, clears the fault flag and drops the result valid;
// it needs no clearing pass, as stale stack memory contents are never used.
module two_stack_infix_evaluator #(
	parameter int STACK_DEPTH = tsie_pkg::STACK_DEPTH_DEF,
	parameter int VALUE_WIDTH = tsie_pkg::VALUE_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	tsie_in_if.sink expr,
	tsie_out_if.source result
);
	import tsie_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int EW = (VALUE_WIDTH > VALUE_OUT_WIDTH) ? VALUE_WIDTH : VALUE_OUT_WIDTH;

	logic accept;
	logic err_q;
	logic err_d;
	logic res_valid_q;
	status_t status_q;
	logic signed [VALUE_OUT_WIDTH-1:0] value_q;

	stack_ctl_t opd_ctl;
	stack_ctl_t opr_ctl;
	logic [VALUE_WIDTH-1:0] opd_push;
	logic [VALUE_WIDTH-1:0] opd_top0;
	logic [VALUE_WIDTH-1:0] opd_top1;
	logic [CW-1:0] opd_cnt;
	logic [1:0] opr_push;
	logic [1:0] opr_top0;
	logic [1:0] opr_top1;
	logic [CW-1:0] opr_cnt;

	logic [CHAR_WIDTH-1:0] ch;
	logic [CHAR_WIDTH-1:0] digit;
	logic [VALUE_WIDTH-1:0] sum;
	logic [VALUE_WIDTH-1:0] diff;
	logic [2*VALUE_WIDTH-1:0] prod;
	logic [VALUE_WIDTH-1:0] res;
	status_t st;
	logic [VALUE_WIDTH-1:0] val;
	logic [EW-1:0] val_ext;

	assign accept = expr.valid && expr.ready;
	assign expr.ready = !res_valid_q || result.ready;
	assign ch = expr.char_code;
	assign digit = ch - CH_ZERO;

	assign sum = opd_top1 + opd_top0;
	assign diff = opd_top1 - opd_top0;
	assign prod = opd_top1 * opd_top0;

	always_comb begin
		case (op_t'(opr_top0))
			OP_ADD: res = sum;
			OP_SUB: res = diff;
			default: res = prod[VALUE_WIDTH-1:0];
		endcase
	end

	always_comb begin
		opd_ctl = '{cmd: STK_NONE, clear: 1'b0};
		opr_ctl = '{cmd: STK_NONE, clear: 1'b0};
		opd_push = res;
		opr_push = OP_OPEN;
		st = ST_ACCEPTED;
		val = '0;
		err_d = err_q;

		if (err_q) begin
			st = ST_FAULT;
		end else begin
			case (ch) inside
				[CH_ZERO:CH_NINE]: begin
					if (opd_cnt >= CW'(STACK_DEPTH)) begin
						st = ST_FAULT;
					end else begin
						opd_ctl.cmd = STK_PUSH;
						opd_push = VALUE_WIDTH'(digit);
						val = VALUE_WIDTH'(digit);
					end
				end
				CH_OPEN, CH_ADD, CH_SUB, CH_MUL: begin
					if (opr_cnt >= CW'(STACK_DEPTH)) begin
						st = ST_FAULT;
					end else begin
						opr_ctl.cmd = STK_PUSH;
						case (ch)
							CH_ADD: opr_push = OP_ADD;
							CH_SUB: opr_push = OP_SUB;
							CH_MUL: opr_push = OP_MUL;
							default: opr_push = OP_OPEN;
						endcase
						val = (opd_cnt != '0) ? opd_top0 : '0;
					end
				end
				CH_CLOSE: begin
					if (opd_cnt < CW'(2) || opr_cnt < CW'(2) ||
						op_t'(opr_top0) == OP_OPEN || op_t'(opr_top1) != OP_OPEN) begin
						st = ST_FAULT;
					end else begin
						opd_ctl.cmd = STK_POP1_REPLACE;
						opr_ctl.cmd = STK_POP2;
						val = res;
					end
				end
				default: st = ST_INVALID;
			endcase
		end

		if (st != ST_ACCEPTED) begin
			err_d = 1'b1;
		end

		if (expr.end_of_expression) begin
			if (st == ST_ACCEPTED) begin
				if (opd_cnt == '0 && opd_ctl.cmd != STK_PUSH) begin
					st = ST_FAULT;
				end else begin
					st = ST_RESULT;
				end
			end else begin
				val = '0;
			end
			opd_ctl = '{cmd: STK_NONE, clear: 1'b1};
			opr_ctl = '{cmd: STK_NONE, clear: 1'b1};
			err_d = 1'b0;
		end

		if (!accept) begin
			opd_ctl = '{cmd: STK_NONE, clear: 1'b0};
			opr_ctl = '{cmd: STK_NONE, clear: 1'b0};
			err_d = err_q;
		end
	end

	assign val_ext = EW'(val);

	tsie_stack #(
		.WIDTH(VALUE_WIDTH),
		.DEPTH(STACK_DEPTH)
	) u_operand_stack (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(opd_ctl),
		.push_data(opd_push),
		.top0(opd_top0),
		.top1(opd_top1),
		.count(opd_cnt)
	);

	tsie_stack #(
		.WIDTH(2),
		.DEPTH(STACK_DEPTH)
	) u_operator_stack (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(opr_ctl),
		.push_data(opr_push),
		.top0(opr_top0),
		.top1(opr_top1),
		.count(opr_cnt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			err_q <= err_d;
			if (accept) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= st;
			value_q <= val_ext[VALUE_OUT_WIDTH-1:0];
		end
	end

	assign result.valid = res_valid_q;
	assign result.status = status_q;
	assign result.value = value_q;

endmodule
